// File: design/signed_decimal_field_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal field formatter
// Clocked on clock, held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define SDF_ASSERT_SAME(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error("same-cycle check failed");

// Check a consequence in the cycle after its cause
`define SDF_ASSERT_NEXT(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("next-cycle check failed");

`endif

// File: design/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Types, constants and helpers shared by the decimal field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 32;
   localparam int VALUE_W           = 32;
   localparam int CHAR_W            = 8;
   // signed length arithmetic, wide enough for lengths up to 127
   localparam int LEN_W             = 8;
   localparam int NUM_DIGITS        = 10;
   localparam int DIGIT_CNT_W       = 4;
   localparam int BCD_W             = 4 * NUM_DIGITS;
   localparam int BCD_IDX_W         = 6;
   localparam int BIT_CNT_W         = 5;
   localparam int WIDTH_W           = 6;
   localparam int PREC_W            = 6;
   localparam int CSR_ADDR_W        = 5;
   localparam int CSR_DATA_W        = 32;
   localparam int REG_IDX_W         = 3;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_TEXT_LEFT      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FILL_ZERO      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PLUS_SIGN      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SPACE_SIGN     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FIELD_WIDTH    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PRECISION_CODE = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_DIGITS,
      ST_SIZE,
      ST_PLACE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                text_left;
      logic                fill_zero;
      logic                plus_sign;
      logic                space_sign;
      logic [WIDTH_W-1:0]  field_width;
      logic [PREC_W-1:0]   precision_code;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic count;
      logic size;
      logic place;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic none;
      logic last;
      logic slot_free;
   } sts_type;

   // powers of ten for the digit count
   function automatic logic [VALUE_W-1:0] pow10(input logic [DIGIT_CNT_W-1:0] k);
      logic [VALUE_W-1:0] p;
      unique case (k)
         4'd1:    p = 32'd10;
         4'd2:    p = 32'd100;
         4'd3:    p = 32'd1000;
         4'd4:    p = 32'd10000;
         4'd5:    p = 32'd100000;
         4'd6:    p = 32'd1000000;
         4'd7:    p = 32'd10000000;
         4'd8:    p = 32'd100000000;
         4'd9:    p = 32'd1000000000;
         default: p = 32'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: design/sdf_req_if.sv
// ----------------------------------------------------------------------------
// sdf_req_if
// Input channel: one signed value per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_req_if;
   logic                         valid;
   logic                         ready;
   logic [sdf_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: design/sdf_rsp_if.sv
// ----------------------------------------------------------------------------
// sdf_rsp_if
// Result channel: one ASCII character per word, with a last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sdf_pkg::CHAR_W-1:0]  character;
   logic                        last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: design/sdf_csr.sv
// ----------------------------------------------------------------------------
// sdf_csr
// APB-style configuration registers for the formatter flags and lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [sdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [sdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output sdf_pkg::cfg_type                       cfg
);

   sdf_pkg::cfg_type                   cfg_ff;
   sdf_pkg::cfg_type                   cfg_in;
   logic [sdf_pkg::REG_IDX_W-1:0]      idx;
   logic                               wr;

   assign idx        = csr_paddr[sdf_pkg::CSR_ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // decode the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            sdf_pkg::REG_TEXT_LEFT:      cfg_in.text_left      = csr_pwdata[0];
            sdf_pkg::REG_FILL_ZERO:      cfg_in.fill_zero      = csr_pwdata[0];
            sdf_pkg::REG_PLUS_SIGN:      cfg_in.plus_sign      = csr_pwdata[0];
            sdf_pkg::REG_SPACE_SIGN:     cfg_in.space_sign     = csr_pwdata[0];
            sdf_pkg::REG_FIELD_WIDTH:
               cfg_in.field_width    = csr_pwdata[sdf_pkg::WIDTH_W-1:0];
            sdf_pkg::REG_PRECISION_CODE:
               cfg_in.precision_code = csr_pwdata[sdf_pkg::PREC_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         sdf_pkg::REG_TEXT_LEFT:      csr_prdata[0] = cfg_ff.text_left;
         sdf_pkg::REG_FILL_ZERO:      csr_prdata[0] = cfg_ff.fill_zero;
         sdf_pkg::REG_PLUS_SIGN:      csr_prdata[0] = cfg_ff.plus_sign;
         sdf_pkg::REG_SPACE_SIGN:     csr_prdata[0] = cfg_ff.space_sign;
         sdf_pkg::REG_FIELD_WIDTH:
            csr_prdata[sdf_pkg::WIDTH_W-1:0] = cfg_ff.field_width;
         sdf_pkg::REG_PRECISION_CODE:
            csr_prdata[sdf_pkg::PREC_W-1:0] = cfg_ff.precision_code;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// File: design/sdf_ctrl.sv
// ----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer: load, bit-serial conversion, sizing steps, character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sdf_pkg::sts_type  sts,
   output sdf_pkg::cmd_type       cmd
);

   sdf_pkg::state_type state_ff;
   sdf_pkg::state_type state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sdf_pkg::ST_CONV;
            end
         end
         sdf_pkg::ST_CONV: begin
            cmd.shift = 1'b1;
            if (sts.conv_done) begin
               state_in = sdf_pkg::ST_DIGITS;
            end
         end
         sdf_pkg::ST_DIGITS: begin
            cmd.count = 1'b1;
            state_in  = sdf_pkg::ST_SIZE;
         end
         sdf_pkg::ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = sdf_pkg::ST_PLACE;
         end
         sdf_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = sdf_pkg::ST_EMIT;
         end
         sdf_pkg::ST_EMIT: begin
            priority if (sts.none) begin
               state_in = sdf_pkg::ST_IDLE;
            end else if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.last) begin
                  state_in = sdf_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sdf_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: design/sdf_dpath.sv
// ----------------------------------------------------------------------------
// sdf_dpath
// Magnitude, double-dabble BCD conversion, field layout and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_dpath #(
   parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [sdf_pkg::VALUE_W-1:0]    req_value,
   input  wire sdf_pkg::cfg_type               cfg,
   input  wire sdf_pkg::cmd_type               cmd,
   output sdf_pkg::sts_type                    sts,
   sdf_rsp_if.source                           rsp_chan
);

   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int LW    = sdf_pkg::LEN_W;
   localparam logic signed [LW-1:0] MAX_LEN = LW'(MAX_WIDTH);

   logic                               neg_ff;
   logic [sdf_pkg::VALUE_W-1:0]        mag_ff;
   logic [sdf_pkg::VALUE_W-1:0]        sh_ff;
   logic [sdf_pkg::BCD_W-1:0]          bcd_ff;
   logic [sdf_pkg::BIT_CNT_W-1:0]      bit_ff;
   logic [sdf_pkg::DIGIT_CNT_W-1:0]    digits_ff;
   logic [sdf_pkg::DIGIT_CNT_W-1:0]    ndig_ff;
   logic                               sgn_ff;
   logic [sdf_pkg::CHAR_W-1:0]         sign_char_ff;
   logic [sdf_pkg::CHAR_W-1:0]         fill_ff;
   logic signed [LW-1:0]               size_ff;
   logic signed [LW-1:0]               width_ff;
   logic signed [LW-1:0]               off_ff;
   logic [CNT_W-1:0]                   emit_ff;
   logic [CNT_W-1:0]                   pos_ff;
   logic                               valid_ff;
   logic [sdf_pkg::CHAR_W-1:0]         char_ff;
   logic                               last_ff;

   logic [sdf_pkg::VALUE_W-1:0]        mag_in;
   logic [sdf_pkg::BCD_W-1:0]          adj;
   logic [sdf_pkg::NUM_DIGITS-2:0]     ge;
   logic signed [LW-1:0]               prec_s;
   logic signed [LW-1:0]               wid_s;
   logic signed [LW-1:0]               dig_s;
   logic signed [LW-1:0]               sgn_s;
   logic signed [LW-1:0]               target;
   logic signed [LW-1:0]               size_in;
   logic signed [LW-1:0]               outlen;
   logic signed [LW-1:0]               cpos;
   logic signed [LW-1:0]               kpos;
   logic [sdf_pkg::BCD_IDX_W-1:0]      dbase;
   logic [3:0]                         digit;
   logic [sdf_pkg::CHAR_W-1:0]         char_in;
   logic                               last_in;

   assign mag_in = req_value[sdf_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   // compare against powers of ten for the digit count
   always_comb begin
      for (int k = 1; k < sdf_pkg::NUM_DIGITS; k++) begin
         ge[k-1] = mag_ff >= sdf_pkg::pow10(sdf_pkg::DIGIT_CNT_W'(k));
      end
   end

   // sizing arithmetic
   always_comb begin
      prec_s = LW'($signed(cfg.precision_code));
      wid_s  = LW'(cfg.field_width);
      if (wid_s > MAX_LEN) begin
         wid_s = MAX_LEN;
      end
      dig_s  = LW'(digits_ff);
      sgn_s  = LW'(sgn_ff);
      if (prec_s == '0 && wid_s > '0 && !cfg.text_left) begin
         target = cfg.fill_zero ? wid_s : dig_s;
      end else begin
         target = prec_s + sgn_s;
      end
      priority if (mag_ff == '0 && prec_s == -LW'(1)) begin
         size_in = sgn_s;
      end else if (dig_s >= target) begin
         size_in = dig_s + sgn_s;
      end else begin
         size_in = target;
      end
      outlen = (width_ff > size_ff) ? width_ff : size_ff;
   end

   // character at the current position; either side of the core is space padding
   always_comb begin
      cpos    = LW'(pos_ff) - off_ff;
      kpos    = size_ff - LW'(1) - cpos;
      dbase   = {kpos[3:0], 2'b00};
      digit   = bcd_ff[dbase +: 4];
      priority if (cpos[LW-1] || cpos >= size_ff) begin
         char_in = sdf_pkg::ASCII_SPACE;
      end else if (cpos == '0 && sgn_ff) begin
         char_in = sign_char_ff;
      end else if (kpos < LW'(ndig_ff)) begin
         char_in = sdf_pkg::ASCII_ZERO + {4'b0000, digit};
      end else begin
         char_in = fill_ff;
      end
      last_in = pos_ff == CNT_W'(emit_ff - 1'b1);
   end

   assign sts.conv_done = bit_ff == '1;
   assign sts.none      = emit_ff == '0;
   assign sts.last      = last_in;
   assign sts.slot_free = !valid_ff || rsp_chan.ready;

   // load and convert
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[sdf_pkg::VALUE_W-1];
         mag_ff <= mag_in;
         sh_ff  <= mag_in;
         bcd_ff <= '0;
         bit_ff <= '0;
      end else if (cmd.shift) begin
         bcd_ff <= {adj[sdf_pkg::BCD_W-2:0], sh_ff[sdf_pkg::VALUE_W-1]};
         sh_ff  <= {sh_ff[sdf_pkg::VALUE_W-2:0], 1'b0};
         bit_ff <= bit_ff + 1'b1;
      end
   end

   // size the field
   always_ff @(posedge clock) begin
      if (cmd.count) begin
         digits_ff <= sdf_pkg::DIGIT_CNT_W'(1 + $countones(ge));
         sgn_ff    <= neg_ff || cfg.plus_sign || cfg.space_sign;
         priority if (neg_ff) begin
            sign_char_ff <= sdf_pkg::ASCII_MINUS;
         end else if (cfg.plus_sign) begin
            sign_char_ff <= sdf_pkg::ASCII_PLUS;
         end else begin
            sign_char_ff <= sdf_pkg::ASCII_SPACE;
         end
         fill_ff <= (cfg.fill_zero || prec_s != -LW'(1))
                    ? sdf_pkg::ASCII_ZERO : sdf_pkg::ASCII_SPACE;
      end
      if (cmd.size) begin
         size_ff  <= size_in;
         width_ff <= wid_s;
         ndig_ff  <= (mag_ff == '0) ? '0 : digits_ff;
      end
      if (cmd.place) begin
         off_ff  <= cfg.text_left ? '0 : outlen - size_ff;
         emit_ff <= (outlen > MAX_LEN) ? CNT_W'(MAX_WIDTH) : CNT_W'(outlen);
         pos_ff  <= '0;
      end else if (cmd.emit) begin
         pos_ff  <= pos_ff + 1'b1;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last      = last_ff;

endmodule

`default_nettype wire

// File: design/signed_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter: %d text of a 32-bit value, one char per word
// An item is accepted, converted bit-serially and sized, then emitted at one
// char per cycle while the result side takes each word: N characters
// (1..MAX_WIDTH) or empty text. One item is finished before the next is taken.
// Reset is synchronous: configuration clears to zero, sequencer goes idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_decimal_field_formatter_assert.svh"

module signed_decimal_field_formatter #(
   parameter int MAX_WIDTH = sdf_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sdf_req_if.sink                                req_chan,
   sdf_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [sdf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [sdf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   sdf_pkg::cfg_type cfg;
   sdf_pkg::cmd_type cmd;
   sdf_pkg::sts_type sts;

   // configuration registers
   sdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   sdf_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_chan.value),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_chan  (rsp_chan)
   );

   // one item in flight at a time
   `SDF_ASSERT_NEXT(a_one_in_flight, req_chan.valid && req_chan.ready, !req_chan.ready)
   // never overwrite a pending word
   `SDF_ASSERT_SAME(a_no_overwrite, cmd.emit, sts.slot_free)
   // last character frees the input
   `SDF_ASSERT_NEXT(a_last_frees, cmd.emit && sts.last, req_chan.ready)

endmodule

`default_nettype wire
